### rtl/utf8dw_pkg.sv
// utf8dw_pkg: shared types, constants and the wide-character interval test
// for the utf-8 display width counter; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package utf8dw_pkg;

    // payload widths fixed by the stream format
    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int CELL_W = 16;
    localparam int WIDE_COUNT = 10;

    // cells added by one decoded code unit (0, 1 or 2)
    localparam int ADD_W = 2;
    localparam logic [ADD_W-1:0] ADD_NONE   = 2'd0;
    localparam logic [ADD_W-1:0] ADD_NARROW = 2'd1;
    localparam logic [ADD_W-1:0] ADD_WIDE   = 2'd2;

    // continuation bytes still awaited
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] lo;
        logic [UNIT_W-1:0] hi;
    } span_t;

    typedef span_t [WIDE_COUNT-1:0] span_table_t;

    // wide intervals of the basic plane; higher planes never fit a 16-bit unit
    localparam span_table_t WIDE_TABLE = '{
        '{lo: 16'hFFE0, hi: 16'hFFE6},
        '{lo: 16'hFF00, hi: 16'hFF60},
        '{lo: 16'hFE30, hi: 16'hFE6F},
        '{lo: 16'hFE10, hi: 16'hFE19},
        '{lo: 16'hF900, hi: 16'hFAFF},
        '{lo: 16'hAC00, hi: 16'hD7A3},
        '{lo: 16'h3040, hi: 16'hA4CF},
        '{lo: 16'h2E80, hi: 16'h303E},
        '{lo: 16'h2329, hi: 16'h232A},
        '{lo: 16'h1100, hi: 16'h115F}
    };

    // decode state of the string in progress
    typedef struct packed {
        logic [1:0]        pending;
        logic [UNIT_W-1:0] partial;
        logic              stopped;
    } dec_state_t;

    // outcome of one byte
    typedef struct packed {
        dec_state_t       next;
        logic [ADD_W-1:0] add_cells;
    } dec_step_t;

    // true when the unit lies in any wide interval
    function automatic logic unit_is_wide(input logic [UNIT_W-1:0] u);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < WIDE_COUNT; k++)
        begin
            if (u >= WIDE_TABLE[k].lo && u <= WIDE_TABLE[k].hi)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

### rtl/utf8dw_ifs.sv
// utf8dw channel interfaces: byte request stream in, width result out
// depends on utf8dw_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface utf8dw_byte_if;
    logic                           valid;
    logic                           ready;
    logic [utf8dw_pkg::BYTE_W-1:0]  text_byte;
    logic                           is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

interface utf8dw_width_if;
    logic                           valid;
    logic                           ready;
    logic [utf8dw_pkg::CELL_W-1:0]  cell_width;

    modport source (output valid, output cell_width, input ready);
    modport sink   (input valid, input cell_width, output ready);
endinterface

`default_nettype wire

### rtl/utf8dw_decode.sv
// utf8dw_decode: one byte of utf-8 decode, giving next decode state and cells
// depends on utf8dw_pkg (state types, wide interval table)
`timescale 1ns / 1ps
`default_nettype none

module utf8dw_decode (
    input  wire utf8dw_pkg::dec_state_t          st,
    input  wire logic [utf8dw_pkg::BYTE_W-1:0]   text_byte,
    output utf8dw_pkg::dec_step_t                step
);

    logic [utf8dw_pkg::UNIT_W-1:0] cont;
    logic [utf8dw_pkg::UNIT_W-1:0] unit;
    logic                          done;

    // low six bits of a continuation byte, top bits not checked
    assign cont = {10'b0, text_byte[5:0]};

    always_comb
    begin
        step.next      = st;
        step.add_cells = utf8dw_pkg::ADD_NONE;
        unit           = '0;
        done           = 1'b0;

        if (!st.stopped)
        begin
            if (st.pending != utf8dw_pkg::PEND_NONE)
            begin
                // continuation byte
                case (st.pending)
                    utf8dw_pkg::PEND_TWO:
                    begin
                        step.next.partial = st.partial | (cont << 6);
                        step.next.pending = utf8dw_pkg::PEND_ONE;
                    end
                    default:
                    begin
                        unit              = st.partial | cont;
                        step.next.partial = unit;
                        step.next.pending = utf8dw_pkg::PEND_NONE;
                        done              = 1'b1;
                    end
                endcase
            end
            else
            begin
                // lead position
                case (text_byte) inside
                    [8'h00:8'h7F]:
                    begin
                        unit = {8'b0, text_byte};
                        done = 1'b1;
                    end
                    [8'hC0:8'hDF]:
                    begin
                        step.next.partial = {5'b0, text_byte[4:0], 6'b0};
                        step.next.pending = utf8dw_pkg::PEND_ONE;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        step.next.partial = {text_byte[3:0], 12'b0};
                        step.next.pending = utf8dw_pkg::PEND_TWO;
                    end
                    default:
                    begin
                        // stray continuation or four-byte lead: skipped alone
                    end
                endcase
            end

            // a finished unit either stops counting or adds cells
            if (done)
            begin
                if (unit == '0)
                begin
                    step.next.stopped = 1'b1;
                end
                else if (utf8dw_pkg::unit_is_wide(unit))
                begin
                    step.add_cells = utf8dw_pkg::ADD_WIDE;
                end
                else
                begin
                    step.add_cells = utf8dw_pkg::ADD_NARROW;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/utf8_display_width_counter_unit.sv
// utf8_display_width_counter_unit: display width of a utf-8 string, byte per clock
// depends on utf8dw_pkg, utf8dw_ifs (channel interfaces) and utf8dw_decode
//
//   channel    dir   payload                      request carries
//   byte_in    in    text_byte[7:0], is_final     one byte of the string
//   width_out  out   cell_width[15:0]             width, once per final byte
//
// one byte accepted per clock while no final byte is stalled; a byte waits in the
// input register, then decode and the saturating add write the state and, on a final
// byte, the result register. result is valid the cycle after its final byte is worked.
// reset clears decode state, width sum and both valid flags.
// a stall on width_out only holds back a final byte; others keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module utf8_display_width_counter_unit #(
    parameter int WIDTH_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    utf8dw_byte_if.sink         byte_in,
    utf8dw_width_if.source      width_out
);

    localparam int SumExtW = (WIDTH_BITS > utf8dw_pkg::CELL_W) ? WIDTH_BITS
                                                               : utf8dw_pkg::CELL_W;

    logic                               in_valid_reg;
    logic [utf8dw_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                               in_final_reg;
    utf8dw_pkg::dec_state_t             state_reg;
    logic [WIDTH_BITS-1:0]              sum_reg;
    logic                               out_valid_reg;
    logic [utf8dw_pkg::CELL_W-1:0]      out_width_reg;

    logic                               out_free;
    logic                               work_fire;
    utf8dw_pkg::dec_step_t              step;
    logic [WIDTH_BITS:0]                sum_grown;
    logic [WIDTH_BITS-1:0]              sum_next;
    logic [SumExtW-1:0]                 sum_ext;

    // handshake: a final byte waits for room in the result register
    assign out_free      = !out_valid_reg || width_out.ready;
    assign work_fire     = in_valid_reg && (!in_final_reg || out_free);
    assign byte_in.ready = !in_valid_reg || work_fire;

    // per-byte decode
    utf8dw_decode u_decode (
        .st        (state_reg),
        .text_byte (in_byte_reg),
        .step      (step)
    );

    // saturating width sum
    assign sum_grown = {1'b0, sum_reg} + (WIDTH_BITS + 1)'(step.add_cells);
    assign sum_next  = sum_grown[WIDTH_BITS] ? {WIDTH_BITS{1'b1}}
                                             : sum_grown[WIDTH_BITS-1:0];
    assign sum_ext   = SumExtW'(sum_next);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg  <= byte_in.text_byte;
            in_final_reg <= byte_in.is_final;
        end
    end

    // string state, cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            sum_reg   <= '0;
        end
        else if (work_fire)
        begin
            if (in_final_reg)
            begin
                state_reg <= '0;
                sum_reg   <= '0;
            end
            else
            begin
                state_reg <= step.next;
                sum_reg   <= sum_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (work_fire && in_final_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (width_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_fire && in_final_reg)
        begin
            out_width_reg <= sum_ext[utf8dw_pkg::CELL_W-1:0];
        end
    end

    assign width_out.valid      = out_valid_reg;
    assign width_out.cell_width = out_width_reg;

    // a final byte that is worked always leaves a result pending
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        work_fire && in_final_reg |=> out_valid_reg)
        else $error("final byte did not load the result register");

    // string state is clear after a final byte
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        work_fire && in_final_reg |=> (state_reg == '0) && (sum_reg == '0))
        else $error("string state not cleared after final byte");

    // never three continuation bytes awaited
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending != 2'd3)
        else $error("continuation count out of range");

    // input only stalls behind a final byte blocked by the result side
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> in_valid_reg && in_final_reg && out_valid_reg)
        else $error("input stalled without a blocked final byte");

endmodule

`default_nettype wire

### dv/utf8_display_width_counter_unit_test.sv
// utf8_display_width_counter_unit_test: drives utf-8 strings byte by byte and checks
// each reported display width against a local decoder and cell counter
// depends on utf8dw_pkg, utf8dw_ifs and utf8_display_width_counter_unit
`timescale 1ns / 1ps

module utf8_display_width_counter_unit_test;

    localparam int WIDTH_BITS = 16;
    localparam int WIDE_SPANS = 10;

    logic clk = 1'b0;
    logic rst_n;

    utf8dw_byte_if  byte_ch ();
    utf8dw_width_if width_ch ();

    utf8_display_width_counter_unit #(
        .WIDTH_BITS(WIDTH_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .width_out (width_ch)
    );

    // decoder state of the string in progress
    logic [1:0]                        dec_pending;
    logic [utf8dw_pkg::UNIT_W-1:0]     dec_partial;
    logic                              dec_stopped;
    logic [WIDTH_BITS-1:0]             cell_total;

    // widths of finished strings still to come out of the block
    logic [utf8dw_pkg::CELL_W-1:0] string_widths[$];
    // bytes of the string being built
    logic [7:0]                    text_bytes[$];

    int fail_count     = 0;
    int rx_hold_cycles = 0;
    bit tx_gaps        = 1'b1;
    bit rx_gaps        = 1'b1;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // wide interval table of the basic plane
    function automatic void span_of(input int k, output logic [15:0] lo,
                                    output logic [15:0] hi);
        case (k)
            0:       begin lo = 16'h1100; hi = 16'h115F; end
            1:       begin lo = 16'h2329; hi = 16'h232A; end
            2:       begin lo = 16'h2E80; hi = 16'h303E; end
            3:       begin lo = 16'h3040; hi = 16'hA4CF; end
            4:       begin lo = 16'hAC00; hi = 16'hD7A3; end
            5:       begin lo = 16'hF900; hi = 16'hFAFF; end
            6:       begin lo = 16'hFE10; hi = 16'hFE19; end
            7:       begin lo = 16'hFE30; hi = 16'hFE6F; end
            8:       begin lo = 16'hFF00; hi = 16'hFF60; end
            default: begin lo = 16'hFFE0; hi = 16'hFFE6; end
        endcase
    endfunction

    function automatic bit in_wide_span(input logic [15:0] u);
        logic [15:0] lo;
        logic [15:0] hi;
        bit          hit;
        hit = 1'b0;
        for (int k = 0; k < WIDE_SPANS; k++)
        begin
            span_of(k, lo, hi);
            if (u >= lo && u <= hi)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void clear_string();
        dec_pending = utf8dw_pkg::PEND_NONE;
        dec_partial = '0;
        dec_stopped = 1'b0;
        cell_total  = '0;
    endfunction

    // saturating add of one code unit's cells
    function automatic void add_cells(input int n);
        logic [WIDTH_BITS:0] wider;
        wider = {1'b0, cell_total} + (WIDTH_BITS + 1)'(n);
        if (wider[WIDTH_BITS])
        begin
            cell_total = '1;
        end
        else
        begin
            cell_total = wider[WIDTH_BITS-1:0];
        end
    endfunction

    // decode one accepted byte; a final byte yields the string width
    function automatic void count_byte(input logic [7:0] b, input logic fin);
        logic [15:0] unit;
        bit          have_unit;
        have_unit = 1'b0;
        unit      = '0;
        if (!dec_stopped)
        begin
            if (dec_pending != utf8dw_pkg::PEND_NONE)
            begin
                if (dec_pending == utf8dw_pkg::PEND_TWO)
                begin
                    dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
                end
                else
                begin
                    dec_partial = dec_partial | {10'b0, b[5:0]};
                end
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == utf8dw_pkg::PEND_NONE)
                begin
                    have_unit = 1'b1;
                    unit      = dec_partial;
                end
            end
            else
            begin
                casez (b)
                    8'b0???????:
                    begin
                        have_unit = 1'b1;
                        unit      = {8'b0, b};
                    end
                    8'b110?????:
                    begin
                        dec_partial = {5'b0, b[4:0], 6'b0};
                        dec_pending = utf8dw_pkg::PEND_ONE;
                    end
                    8'b1110????:
                    begin
                        dec_partial = {b[3:0], 12'b0};
                        dec_pending = utf8dw_pkg::PEND_TWO;
                    end
                    default:
                    begin
                        // stray or 4-byte lead, skipped alone
                    end
                endcase
            end
        end
        if (have_unit)
        begin
            if (unit == '0)
            begin
                dec_stopped = 1'b1;
            end
            else
            begin
                add_cells(in_wide_span(unit) ? 2 : 1);
            end
        end
        if (fin)
        begin
            string_widths.push_back(cell_total);
            clear_string();
        end
    endfunction

    // continuation byte, now and then with wrong top bits
    function automatic logic [7:0] cont_byte(input logic [5:0] v);
        logic [1:0] top;
        top = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b10;
        return {top, v};
    endfunction

    function automatic void push_three(input logic [15:0] u);
        text_bytes.push_back({4'b1110, u[15:12]});
        text_bytes.push_back(cont_byte(u[11:6]));
        text_bytes.push_back(cont_byte(u[5:0]));
    endfunction

    // unit at or next to a wide interval edge, or inside one
    function automatic logic [15:0] edge_unit();
        logic [15:0] lo;
        logic [15:0] hi;
        span_of($urandom_range(0, WIDE_SPANS - 1), lo, hi);
        case ($urandom_range(0, 4))
            0:       return lo - 16'd1;
            1:       return lo;
            2:       return hi;
            3:       return hi + 16'd1;
            default: return 16'($urandom_range(int'(lo), int'(hi)));
        endcase
    endfunction

    // append one character, mostly well formed, sometimes noise
    function automatic void push_char();
        int unsigned kind;
        logic [15:0] u;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            text_bytes.push_back(8'($urandom_range(1, 127)));
        end
        else if (kind < 45)
        begin
            u = 16'($urandom_range(16'h0080, 16'h07FF));
            text_bytes.push_back({3'b110, u[10:6]});
            text_bytes.push_back(cont_byte(u[5:0]));
        end
        else if (kind < 70)
        begin
            push_three(edge_unit());
        end
        else if (kind < 85)
        begin
            push_three(16'($urandom_range(16'h0800, 16'hFFFF)));
        end
        else
        begin
            case ($urandom_range(0, 6))
                0: text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                1: text_bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
                2: text_bytes.push_back(8'h00);
                3:
                begin
                    // three-byte lead cut short
                    text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    text_bytes.push_back(cont_byte(6'($urandom)));
                end
                4: text_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                5: text_bytes.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    // overlong zero
                    text_bytes.push_back(8'hC0);
                    text_bytes.push_back(8'h80);
                end
            endcase
        end
    endfunction

    // one byte request; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (tx_gaps && $urandom_range(0, 99) < 25)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.text_byte <= b;
        byte_ch.is_final  <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        count_byte(b, fin);
        @(negedge clk);
    endtask

    // whole string from text_bytes, final mark on its last byte
    task automatic send_string();
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
        text_bytes.delete();
    endtask

    task automatic release_sender();
        byte_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        release_sender();
        while (string_widths.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // plain ascii, a lone zero byte and the top two- and three-byte units
    task automatic test_plain_ascii();
        text_bytes = '{8'h41, 8'h7F};
        send_string();
        text_bytes = '{8'h00};
        send_string();
        text_bytes = '{8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
        send_string();
    endtask

    // wide units and their neighbours
    task automatic test_wide_units();
        text_bytes = '{8'hE3, 8'h81, 8'h82, 8'hEA, 8'hB0, 8'h80, 8'hE3, 8'h80, 8'hBF};
        send_string();
    endtask

    // zero lead, overlong zero and zero as continuation
    task automatic test_zero_unit();
        text_bytes = '{8'h41, 8'h00, 8'h41, 8'h41};
        send_string();
        text_bytes = '{8'hC0, 8'h80, 8'h41};
        send_string();
        text_bytes = '{8'hC3, 8'h00};
        send_string();
    endtask

    // stray continuations and high leads
    task automatic test_stray_bytes();
        text_bytes = '{8'h80, 8'hF0, 8'hF8, 8'hFF, 8'h41};
        send_string();
        text_bytes = '{8'hBF};
        send_string();
    endtask

    // unfinished sequence at the end of a string
    task automatic test_incomplete_end();
        text_bytes = '{8'h41, 8'hE3, 8'h81};
        send_string();
        text_bytes = '{8'hC5};
        send_string();
    endtask

    // receiver holds off while short strings keep coming
    task automatic test_pressure();
        tx_gaps        = 1'b0;
        rx_hold_cycles = 200;
        repeat (40)
        begin
            push_char();
            send_string();
        end
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    // long string of wide units, bytes back to back on both sides
    task automatic test_long_wide();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (30)
        begin
            send_byte(8'hE4, 1'b0);
            send_byte(8'hB8, 1'b0);
            send_byte(8'h80, 1'b0);
        end
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
        wait_drained();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // random strings, first with idling on both sides, then without
    task automatic test_random_mix();
        int sent;
        sent = 0;
        while (sent < 950)
        begin
            repeat ($urandom_range(1, 8))
            begin
                push_char();
            end
            sent += text_bytes.size();
            send_string();
        end
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        sent    = 0;
        while (sent < 300)
        begin
            repeat ($urandom_range(1, 8))
            begin
                push_char();
            end
            sent += text_bytes.size();
            send_string();
        end
        release_sender();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // receiver: long hold-off on request, else random stalls
    initial
    begin
        width_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                width_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else
            begin
                width_ch.ready <= !(rx_gaps && $urandom_range(0, 99) < 25);
            end
        end
    end

    // compare each accepted width with the oldest one predicted
    always @(posedge clk)
    begin
        if (rst_n && width_ch.valid && width_ch.ready)
        begin
            if (string_widths.size() == 0)
            begin
                $error("cell_width: no result expected, got %0d", width_ch.cell_width);
                fail_count++;
            end
            else
            begin
                if (width_ch.cell_width !== string_widths[0])
                begin
                    $error("cell_width mismatch: expected %0d, actual %0d",
                           string_widths[0], width_ch.cell_width);
                    fail_count++;
                end
                void'(string_widths.pop_front());
            end
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int guard;
        guard             = 0;
        byte_ch.valid     = 1'b0;
        byte_ch.text_byte = '0;
        byte_ch.is_final  = 1'b0;
        rst_n             = 1'b0;
        clear_string();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_plain_ascii();
        test_wide_units();
        test_zero_unit();
        test_stray_bytes();
        test_incomplete_end();
        release_sender();
        test_pressure();
        test_long_wide();
        test_random_mix();

        // let the last widths come out
        while (string_widths.size() != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (string_widths.size() != 0)
        begin
            $error("cell_width: %0d results never arrived", string_widths.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
